>>> design/monitor_list_stream_parser_defines.svh
// assertion macros used by the monitor list stream parser core
`ifndef MONITOR_LIST_STREAM_PARSER_DEFINES_SVH
`define MONITOR_LIST_STREAM_PARSER_DEFINES_SVH

// property checked on every rising edge of clk_i outside of reset
`define MLSP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// property checked on every rising edge of clk_i, reset included
`define MLSP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> design/mlsp_pkg.sv
// types and constants of the monitor list stream parser
package mlsp_pkg;

  // fixed header bytes kept before the name length byte arrives
  localparam int StoredLen = 17;

  typedef enum logic [1:0] {
    PH_COUNT = 2'd0,
    PH_FIXED = 2'd1,
    PH_NAME  = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HDR   = 2'd0,
    KIND_NAME  = 2'd1,
    KIND_OK    = 2'd2,
    KIND_TRUNC = 2'd3
  } kind_e;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         record_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_w;
    logic signed [31:0] size_h;
    logic               is_primary;
    logic [7:0]         label_len;
    logic [7:0]         label_char;
    logic [7:0]         char_pos;
  } res_t;

endpackage

>>> design/mlsp_in_reg.sv
// input register stage of the monitor list stream parser
module mlsp_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_vld_i,
  output logic          s_rdy_o,
  input  mlsp_pkg::item_t s_item_i,
  input  logic          take_i,
  output logic          vld_o,
  output mlsp_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  mlsp_pkg::item_t item_q;
  logic            accept;

  assign s_rdy_o = !vld_q || take_i;
  assign accept  = s_vld_i && s_rdy_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= s_item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

>>> design/mlsp_core.sv
// record parser: phase tracking, header byte shift line and result forming
`include "monitor_list_stream_parser_defines.svh"

module mlsp_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_vld_i,
  input  mlsp_pkg::item_t item_i,
  input  logic            out_free_i,
  output logic            take_o,
  output logic            res_vld_o,
  output mlsp_pkg::res_t  res_o
);

  mlsp_pkg::phase_e phase_q, phase_d;
  logic [7:0] rec_left_q, rec_left_d;
  logic [7:0] cur_q, cur_d;
  logic [4:0] fixed_cnt_q, fixed_cnt_d;
  logic [7:0] name_left_q, name_left_d;
  logic [7:0] name_pos_q, name_pos_d;
  logic [7:0] hdr_q [mlsp_pkg::StoredLen];
  logic       shift_en;
  logic [7:0] rec_left_dec;
  logic [7:0] name_left_dec;
  logic [7:0] b;

  assign take_o        = in_vld_i && out_free_i;
  assign b             = item_i.data_byte;
  assign rec_left_dec  = rec_left_q - 8'd1;
  assign name_left_dec = name_left_q - 8'd1;

  always_comb begin
    phase_d     = phase_q;
    rec_left_d  = rec_left_q;
    cur_d       = cur_q;
    fixed_cnt_d = fixed_cnt_q;
    name_left_d = name_left_q;
    name_pos_d  = name_pos_q;
    shift_en    = 1'b0;
    res_vld_o   = 1'b0;
    res_o       = '0;
    if (take_o) begin
      if (item_i.action) begin
        res_vld_o          = 1'b1;
        res_o.kind         = (phase_q == mlsp_pkg::PH_DONE) ? mlsp_pkg::KIND_OK
                                                            : mlsp_pkg::KIND_TRUNC;
        res_o.record_index = cur_q;
        phase_d     = mlsp_pkg::PH_COUNT;
        rec_left_d  = '0;
        cur_d       = '0;
        fixed_cnt_d = '0;
        name_left_d = '0;
        name_pos_d  = '0;
      end else begin
        unique case (phase_q)
          mlsp_pkg::PH_COUNT: begin
            rec_left_d  = b;
            cur_d       = '0;
            fixed_cnt_d = '0;
            phase_d     = (b == 8'd0) ? mlsp_pkg::PH_DONE : mlsp_pkg::PH_FIXED;
          end
          mlsp_pkg::PH_FIXED: begin
            if (fixed_cnt_q < 5'(mlsp_pkg::StoredLen)) begin
              shift_en    = 1'b1;
              fixed_cnt_d = fixed_cnt_q + 5'd1;
            end else begin
              // name length byte closes the header
              res_vld_o          = 1'b1;
              res_o.kind         = mlsp_pkg::KIND_HDR;
              res_o.record_index = cur_q;
              res_o.pos_x        = {hdr_q[0], hdr_q[1], hdr_q[2], hdr_q[3]};
              res_o.pos_y        = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
              res_o.size_w       = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
              res_o.size_h       = {hdr_q[12], hdr_q[13], hdr_q[14], hdr_q[15]};
              res_o.is_primary   = (hdr_q[16] != 8'd0);
              res_o.label_len    = b;
              fixed_cnt_d        = '0;
              if (b == 8'd0) begin
                rec_left_d = rec_left_dec;
                cur_d      = cur_q + 8'd1;
                phase_d    = (rec_left_dec == 8'd0) ? mlsp_pkg::PH_DONE
                                                    : mlsp_pkg::PH_FIXED;
              end else begin
                name_left_d = b;
                name_pos_d  = '0;
                phase_d     = mlsp_pkg::PH_NAME;
              end
            end
          end
          mlsp_pkg::PH_NAME: begin
            res_vld_o          = 1'b1;
            res_o.kind         = mlsp_pkg::KIND_NAME;
            res_o.record_index = cur_q;
            res_o.label_char   = b;
            res_o.char_pos     = name_pos_q;
            name_pos_d         = name_pos_q + 8'd1;
            name_left_d        = name_left_dec;
            if (name_left_dec == 8'd0) begin
              rec_left_d  = rec_left_dec;
              cur_d       = cur_q + 8'd1;
              fixed_cnt_d = '0;
              phase_d     = (rec_left_dec == 8'd0) ? mlsp_pkg::PH_DONE
                                                   : mlsp_pkg::PH_FIXED;
            end
          end
          mlsp_pkg::PH_DONE: begin
            // trailing bytes are dropped
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= mlsp_pkg::PH_COUNT;
      rec_left_q  <= '0;
      cur_q       <= '0;
      fixed_cnt_q <= '0;
      name_left_q <= '0;
      name_pos_q  <= '0;
    end else begin
      phase_q     <= phase_d;
      rec_left_q  <= rec_left_d;
      cur_q       <= cur_d;
      fixed_cnt_q <= fixed_cnt_d;
      name_left_q <= name_left_d;
      name_pos_q  <= name_pos_d;
    end
  end

  // oldest header byte ends up at index 0
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < mlsp_pkg::StoredLen - 1; i++) begin
        hdr_q[i] <= hdr_q[i+1];
      end
      hdr_q[mlsp_pkg::StoredLen-1] <= b;
    end
  end

  `MLSP_ASSERT(a_cnt_range, fixed_cnt_q <= 5'(mlsp_pkg::StoredLen), "header count overrun")
  `MLSP_ASSERT(a_name_left, (phase_q == mlsp_pkg::PH_NAME) |-> (name_left_q != 8'd0), "empty name phase")
  `MLSP_ASSERT(a_res_slot, res_vld_o |-> out_free_i, "result formed without a free slot")
  `MLSP_ASSERT(a_end_reset, (take_o && item_i.action) |=> (phase_q == mlsp_pkg::PH_COUNT && cur_q == 8'd0), "end item left state behind")

endmodule

>>> design/mlsp_out_reg.sv
// result register stage of the monitor list stream parser
module mlsp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  mlsp_pkg::res_t res_i,
  output logic           free_o,
  output logic           m_vld_o,
  input  logic           m_rdy_i,
  output mlsp_pkg::res_t m_res_o
);

  logic           vld_q, vld_d;
  mlsp_pkg::res_t res_q;

  assign free_o = !vld_q || m_rdy_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = 1'b1;
    end else if (m_rdy_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign m_vld_o = vld_q;
  assign m_res_o = res_q;

endmodule

>>> design/monitor_list_stream_parser.sv
// top level of the monitor list stream parser
//
//  channel | direction | tdata                  | tuser
//  s_*     | in        | data_byte [7:0]        | action [0]
//  m_*     | out       | result fields, 168 bit | kind [1:0]
//
// one item per cycle while the result side keeps up: an accepted byte is held in the input
// register, then the parser decides and writes the result register
// result valid is registered and rises when the parser writes the result register
// the parser holds every byte, even one that yields no result, while the result
// register is full and not being drained
// reset clears phase, counters and valid flags; the header shift line is not reset
// an end of buffer item returns the parser to its reset state
module monitor_list_stream_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [7:0]   s_tdata_i,   // [7:0] data_byte
  input  logic [0:0]   s_tuser_i,   // [0] action
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // [7:0] record_index, [39:8] pos_x, [71:40] pos_y, [103:72] size_w,
  // [135:104] size_h, [136] is_primary, [144:137] label_len,
  // [152:145] label_char, [160:153] char_pos, [167:161] zero
  output logic [167:0] m_tdata_o,
  output logic [1:0]   m_tuser_o    // [1:0] kind
);

  mlsp_pkg::item_t s_item;
  mlsp_pkg::item_t item;
  mlsp_pkg::res_t  res;
  mlsp_pkg::res_t  m_res;
  logic            in_vld;
  logic            take;
  logic            res_vld;
  logic            out_free;

  assign s_item.action    = s_tuser_i[0];
  assign s_item.data_byte = s_tdata_i;

  // input register
  mlsp_in_reg u_in_reg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_vld_i  (s_tvalid_i),
    .s_rdy_o  (s_tready_o),
    .s_item_i (s_item),
    .take_i   (take),
    .vld_o    (in_vld),
    .item_o   (item)
  );

  // parse state and result forming
  mlsp_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_vld_i   (in_vld),
    .item_i     (item),
    .out_free_i (out_free),
    .take_o     (take),
    .res_vld_o  (res_vld),
    .res_o      (res)
  );

  // result register, loaded only when a result is formed
  mlsp_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_vld),
    .res_i   (res),
    .free_o  (out_free),
    .m_vld_o (m_tvalid_o),
    .m_rdy_i (m_tready_i),
    .m_res_o (m_res)
  );

  assign m_tuser_o = m_res.kind;
  assign m_tdata_o = {7'd0, m_res.char_pos, m_res.label_char, m_res.label_len,
                      m_res.is_primary, m_res.size_h, m_res.size_w, m_res.pos_y,
                      m_res.pos_x, m_res.record_index};

endmodule

>>> test/tb_monitor_list_stream_parser.sv
// testbench of the monitor list stream parser: directed table, random lists, predictor check
module tb_monitor_list_stream_parser;

  localparam int CycleLimit = 900000;
  localparam int ItemGoal   = 1100;
  localparam int MaxShown   = 10;

  logic         clk_i      = 1'b0;
  logic         rst_ni     = 1'b0;
  logic         s_tvalid_i = 1'b0;
  logic         s_tready_o;
  logic [7:0]   s_tdata_i  = 8'h00;   // [7:0] data_byte
  logic [0:0]   s_tuser_i  = 1'b0;    // [0] action
  logic         m_tvalid_o;
  logic         m_tready_i = 1'b0;
  // [7:0] record_index, [39:8] pos_x, [71:40] pos_y, [103:72] size_w,
  // [135:104] size_h, [136] is_primary, [144:137] label_len,
  // [152:145] label_char, [160:153] char_pos
  logic [167:0] m_tdata_o;
  logic [1:0]   m_tuser_o;            // [1:0] kind

  monitor_list_stream_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // one row of the directed part; typed rows carry their ok or truncated result
  typedef struct {
    logic            act;
    logic [7:0]      data;
    bit              typed;
    mlsp_pkg::kind_e kind;
    logic [7:0]      idx;
  } row_t;

  // parser state as predicted
  mlsp_pkg::phase_e pr_phase;
  logic [7:0]       pr_left;
  logic [7:0]       pr_rec;
  logic [4:0]       pr_fcnt;
  logic [7:0]       pr_fixed [mlsp_pkg::StoredLen];
  logic [7:0]       pr_name_left;
  logic [7:0]       pr_name_pos;

  mlsp_pkg::res_t parsed_q [$];
  int   mismatches = 0;
  int   cycle_cnt  = 0;
  int   items_used = 0;
  bit   quiet      = 1'b0;
  int   sink_hold  = 0;

  function automatic void clear_parser();
    pr_phase     = mlsp_pkg::PH_COUNT;
    pr_left      = 8'd0;
    pr_rec       = 8'd0;
    pr_fcnt      = 5'd0;
    pr_name_left = 8'd0;
    pr_name_pos  = 8'd0;
  endfunction

  function automatic void close_record();
    pr_left  = pr_left - 8'd1;
    pr_rec   = pr_rec + 8'd1;
    pr_fcnt  = 5'd0;
    pr_phase = (pr_left == 8'd0) ? mlsp_pkg::PH_DONE : mlsp_pkg::PH_FIXED;
  endfunction

  function automatic logic [31:0] be_word(input int base);
    return {pr_fixed[base], pr_fixed[base+1], pr_fixed[base+2], pr_fixed[base+3]};
  endfunction

  // steps the predicted parser by one item; returns 1 when a result is due
  function automatic bit parse_byte(input logic act, input logic [7:0] b,
                                    output mlsp_pkg::res_t r);
    r = '0;
    if (act) begin
      r.kind         = (pr_phase == mlsp_pkg::PH_DONE) ? mlsp_pkg::KIND_OK
                                                       : mlsp_pkg::KIND_TRUNC;
      r.record_index = pr_rec;
      clear_parser();
      return 1'b1;
    end
    case (pr_phase)
      mlsp_pkg::PH_COUNT: begin
        pr_left  = b;
        pr_rec   = 8'd0;
        pr_fcnt  = 5'd0;
        pr_phase = (b == 8'd0) ? mlsp_pkg::PH_DONE : mlsp_pkg::PH_FIXED;
        return 1'b0;
      end
      mlsp_pkg::PH_FIXED: begin
        if (pr_fcnt < 5'(mlsp_pkg::StoredLen)) begin
          pr_fixed[pr_fcnt] = b;
          pr_fcnt = pr_fcnt + 5'd1;
          return 1'b0;
        end
        // name length byte completes the header
        r.kind         = mlsp_pkg::KIND_HDR;
        r.record_index = pr_rec;
        r.pos_x        = be_word(0);
        r.pos_y        = be_word(4);
        r.size_w       = be_word(8);
        r.size_h       = be_word(12);
        r.is_primary   = (pr_fixed[16] != 8'd0);
        r.label_len    = b;
        pr_fcnt        = 5'd0;
        if (b == 8'd0) begin
          close_record();
        end else begin
          pr_name_left = b;
          pr_name_pos  = 8'd0;
          pr_phase     = mlsp_pkg::PH_NAME;
        end
        return 1'b1;
      end
      mlsp_pkg::PH_NAME: begin
        r.kind         = mlsp_pkg::KIND_NAME;
        r.record_index = pr_rec;
        r.label_char   = b;
        r.char_pos     = pr_name_pos;
        pr_name_pos    = pr_name_pos + 8'd1;
        pr_name_left   = pr_name_left - 8'd1;
        if (pr_name_left == 8'd0) begin
          close_record();
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic string fmt_res(input mlsp_pkg::res_t r);
    return $sformatf("kind=%0d idx=%0d x=%0d y=%0d w=%0d h=%0d prim=%0d len=%0d chr=%0d pos=%0d",
                     r.kind, r.record_index, r.pos_x, r.pos_y, r.size_w, r.size_h,
                     r.is_primary, r.label_len, r.label_char, r.char_pos);
  endfunction

  // mostly no gap or a short one, a few long ones, none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // extremes show up often in header fields
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // drives one item and waits for its handshake, then records what it should yield
  task automatic push_byte(input logic act, input logic [7:0] b, input bit typed,
                           input mlsp_pkg::res_t typed_res);
    int             gap;
    mlsp_pkg::res_t r;
    bit             due;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= act;
    s_tdata_i  <= b;
    do @(posedge clk_i); while (!s_tready_o);
    items_used++;
    due = parse_byte(act, b, r);
    if (typed) begin
      parsed_q.insert(parsed_q.size(), typed_res);
    end else if (due) begin
      parsed_q.insert(parsed_q.size(), r);
    end
  endtask

  // result side: random stalls, long ones now and then
  always @(posedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (quiet || !m_tready_i) begin
      m_tready_i <= 1'b1;
      sink_hold  <= quiet ? 0 : $urandom_range(0, 12);
    end else begin
      m_tready_i <= 1'b0;
      sink_hold  <= ($urandom_range(9) == 0) ? $urandom_range(8, 35) : $urandom_range(0, 2);
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    mlsp_pkg::res_t got;
    mlsp_pkg::res_t want;
    if (rst_ni && m_tvalid_o && m_tready_i) begin
      got.kind         = mlsp_pkg::kind_e'(m_tuser_o);
      got.record_index = m_tdata_o[7:0];
      got.pos_x        = m_tdata_o[39:8];
      got.pos_y        = m_tdata_o[71:40];
      got.size_w       = m_tdata_o[103:72];
      got.size_h       = m_tdata_o[135:104];
      got.is_primary   = m_tdata_o[136];
      got.label_len    = m_tdata_o[144:137];
      got.label_char   = m_tdata_o[152:145];
      got.char_pos     = m_tdata_o[160:153];
      if (parsed_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxShown) $display("unexpected result: %s", fmt_res(got));
      end else begin
        want = parsed_q.pop_front();
        if (got.kind !== want.kind || got.record_index !== want.record_index ||
            got.pos_x !== want.pos_x || got.pos_y !== want.pos_y ||
            got.size_w !== want.size_w || got.size_h !== want.size_h ||
            got.is_primary !== want.is_primary || got.label_len !== want.label_len ||
            got.label_char !== want.label_char || got.char_pos !== want.char_pos) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("mismatch at cycle %0d", cycle_cnt);
            $display("  expected %s", fmt_res(want));
            $display("  actual   %s", fmt_res(got));
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    row_t           plan [25];
    mlsp_pkg::res_t typed_res;
    logic [7:0]     list_bytes [$];
    int             nrec;
    int             nlen;
    int             style;
    int             cut;
    int             wait_cnt;

    // empty buffer, zero count with a trailing byte, then a record with extreme
    // values and no name followed by a cut second record
    plan = '{
      '{1'b1, 8'hFF, 1'b1, mlsp_pkg::KIND_TRUNC, 8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hC3, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b1, 8'h00, 1'b1, mlsp_pkg::KIND_OK,    8'd0},
      '{1'b0, 8'h02, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h7F, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h80, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'hFF, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h80, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h00, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b0, 8'h5A, 1'b0, mlsp_pkg::KIND_HDR,   8'd0},
      '{1'b1, 8'h00, 1'b1, mlsp_pkg::KIND_TRUNC, 8'd1}
    };

    clear_parser();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      typed_res              = '0;
      typed_res.kind         = plan[i].kind;
      typed_res.record_index = plan[i].idx;
      push_byte(plan[i].act, plan[i].data, plan[i].typed, typed_res);
    end

    // random lists: mostly well formed, some cut short, some pure noise
    while (items_used < ItemGoal) begin
      quiet = ($urandom_range(3) == 0);
      style = $urandom_range(99);
      list_bytes.delete();
      if (style < 10) begin
        repeat ($urandom_range(0, 30))
          list_bytes.insert(list_bytes.size(), 8'($urandom_range(255)));
      end else begin
        nrec = ($urandom_range(9) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3);
        list_bytes.insert(list_bytes.size(), 8'(nrec));
        repeat (nrec) begin
          repeat (16) list_bytes.insert(list_bytes.size(), pick_byte());
          list_bytes.insert(list_bytes.size(),
                            ($urandom_range(2) == 0) ? 8'h00 : 8'($urandom_range(255)));
          case ($urandom_range(39))
            0:       nlen = 255;
            1, 2, 3: nlen = $urandom_range(8, 40);
            default: nlen = $urandom_range(0, 5);
          endcase
          list_bytes.insert(list_bytes.size(), 8'(nlen));
          repeat (nlen) list_bytes.insert(list_bytes.size(), 8'($urandom_range(255)));
        end
        // trailing bytes past the last record
        if ($urandom_range(9) < 3) begin
          repeat ($urandom_range(1, 4))
            list_bytes.insert(list_bytes.size(), 8'($urandom_range(255)));
        end
        if (style < 30) begin
          cut = $urandom_range(0, list_bytes.size() - 1);
          while (list_bytes.size() > cut) void'(list_bytes.pop_back());
        end
      end
      foreach (list_bytes[i]) push_byte(1'b0, list_bytes[i], 1'b0, '0);
      push_byte(1'b1, 8'($urandom_range(255)), 1'b0, '0);
    end

    s_tvalid_i <= 1'b0;
    quiet = 1'b0;
    wait_cnt = 0;
    while (parsed_q.size() != 0 && wait_cnt < 2000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    // pipeline of input and result registers, so a short pause catches any stray result
    repeat (10) @(posedge clk_i);
    if (parsed_q.size() != 0) begin
      mismatches++;
      $display("%0d predicted results never arrived", parsed_q.size());
    end
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/mlsp_pkg.sv
design/mlsp_in_reg.sv
design/mlsp_core.sv
design/mlsp_out_reg.sv
design/monitor_list_stream_parser.sv
test/tb_monitor_list_stream_parser.sv
